@@ rtl/catmull_rom_closed_curve_eval_core_defines.svh @@
// Assertion macros used by the curve evaluator controller.
`ifndef CATMULL_ROM_CLOSED_CURVE_EVAL_CORE_DEFINES_SVH
`define CATMULL_ROM_CLOSED_CURVE_EVAL_CORE_DEFINES_SVH
// Same-cycle implication, checked on every rising edge outside reset.
`define CRCE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define CRCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/crce_pkg.sv @@
// Package with types, constants and helpers of the curve evaluator.
`timescale 1ns / 1ps
package crce_pkg;
	localparam int MAX_POINTS = 64;
	localparam int PTR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int COORD_W = 32;
	localparam int PARAM_W = 16;
	localparam int ACC_W = COORD_W + 8;
	localparam int PROD_W = ACC_W + PARAM_W + 1;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_EVAL   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FEW  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_READ,
		ST_MUL,
		ST_ACC,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]                op;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [PARAM_W-1:0]        curve_param;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] tan_x;
		logic signed [COORD_W-1:0] tan_y;
		logic signed [COORD_W-1:0] tan_z;
		logic [1:0]                status;
	} out_t;

	typedef struct packed {
		logic       latch;
		logic       dispatch;
		logic       rd_en;
		logic       cap_en;
		logic [1:0] cap_sel;
		logic       mul_en;
		logic       acc_en;
		logic       fin_en;
		logic [2:0] step;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic few;
		logic full;
	} stat_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W:0] v);
		logic signed [ACC_W:0] hi;
		logic signed [ACC_W:0] lo;
		hi = (ACC_W+1)'({1'b0, {(COORD_W-1){1'b1}}});
		lo = -hi - (ACC_W+1)'(1);
		if (v > hi) begin
			sat_coord = hi[COORD_W-1:0];
		end else if (v < lo) begin
			sat_coord = lo[COORD_W-1:0];
		end else begin
			sat_coord = v[COORD_W-1:0];
		end
	endfunction
endpackage

@@ rtl/crce_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module crce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ rtl/crce_ctrl.sv @@
// Controller state machine that sequences append, clear and evaluate transactions.
`timescale 1ns / 1ps
`include "catmull_rom_closed_curve_eval_core_defines.svh"
module crce_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  crce_pkg::stat_t stat,
	output crce_pkg::cmd_t  cmd
);
	crce_pkg::state_t state_q, state_d;
	logic [2:0] rd_cnt_q;
	logic [1:0] axis_q;
	logic [2:0] step_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			crce_pkg::ST_IDLE: begin
				if (start) state_d = crce_pkg::ST_DISPATCH;
			end
			crce_pkg::ST_DISPATCH: begin
				if (stat.op == crce_pkg::OP_EVAL && !stat.few) begin
					state_d = crce_pkg::ST_READ;
				end else begin
					state_d = crce_pkg::ST_DONE;
				end
			end
			crce_pkg::ST_READ: begin
				if (rd_cnt_q == 3'd4) state_d = crce_pkg::ST_MUL;
			end
			crce_pkg::ST_MUL: state_d = crce_pkg::ST_ACC;
			crce_pkg::ST_ACC: begin
				state_d = (step_q == 3'd4) ? crce_pkg::ST_FIN : crce_pkg::ST_MUL;
			end
			crce_pkg::ST_FIN: begin
				state_d = (axis_q == 2'd2) ? crce_pkg::ST_DONE : crce_pkg::ST_MUL;
			end
			crce_pkg::ST_DONE: state_d = crce_pkg::ST_IDLE;
			default: state_d = crce_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.step = step_q;
		cmd.axis = axis_q;
		cmd.cap_sel = 2'(rd_cnt_q - 3'd1);
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			crce_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.latch = start;
			end
			crce_pkg::ST_DISPATCH: cmd.dispatch = 1'b1;
			crce_pkg::ST_READ: begin
				cmd.rd_en = (rd_cnt_q != 3'd4);
				cmd.cap_en = (rd_cnt_q != 3'd0);
			end
			crce_pkg::ST_MUL: cmd.mul_en = 1'b1;
			crce_pkg::ST_ACC: cmd.acc_en = 1'b1;
			crce_pkg::ST_FIN: cmd.fin_en = 1'b1;
			crce_pkg::ST_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crce_pkg::ST_IDLE;
			rd_cnt_q <= '0;
			axis_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				crce_pkg::ST_IDLE: begin
					rd_cnt_q <= '0;
					axis_q <= '0;
					step_q <= '0;
				end
				crce_pkg::ST_READ: rd_cnt_q <= rd_cnt_q + 3'd1;
				crce_pkg::ST_ACC: begin
					if (step_q != 3'd4) step_q <= step_q + 3'd1;
				end
				crce_pkg::ST_FIN: begin
					step_q <= '0;
					axis_q <= axis_q + 2'd1;
				end
				default: rd_cnt_q <= rd_cnt_q;
			endcase
		end
	end

	`CRCE_ASSERT_NEXT(a_done_one_cycle, done, !done, "result strobe longer than one cycle")
	`CRCE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`CRCE_ASSERT_NOW(a_read_bound, state_q == crce_pkg::ST_READ, rd_cnt_q <= 3'd4,
		"point read counter overran")
	`CRCE_ASSERT_NOW(a_step_bound, cmd.mul_en || cmd.acc_en, step_q <= 3'd4 && axis_q <= 2'd2,
		"basis step or axis out of range")
endmodule

@@ rtl/crce_dp.sv @@
// Datapath: point store, segment lookup, shared fraction multiplier and result registers.
`timescale 1ns / 1ps
module crce_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  crce_pkg::in_t   req,
	input  crce_pkg::cmd_t  cmd,
	output crce_pkg::stat_t stat,
	output crce_pkg::out_t  rsp
);
	localparam int CW = crce_pkg::COORD_W;
	localparam int AW = crce_pkg::ACC_W;
	localparam int PW = crce_pkg::PARAM_W;
	localparam int NW = crce_pkg::CNT_W;
	localparam int IW = crce_pkg::PTR_W;

	logic [NW-1:0] count_q;
	crce_pkg::op_t op_q;
	crce_pkg::in_t req_q;
	logic [NW-1:0] seg_q;
	logic [PW-1:0] t_q;
	logic [IW-1:0] idx_q;
	logic signed [CW-1:0] pt_q [4][3];
	logic signed [crce_pkg::PROD_W-1:0] mul_q;
	logic signed [AW-1:0] hacc_q, gacc_q;
	logic signed [CW-1:0] pos_q [3];
	logic signed [CW-1:0] tan_q [3];
	logic [1:0] status_q;

	logic [PW+NW-1:0] prod;
	logic [IW-1:0] idx_next;
	logic [IW-1:0] ram_addr;
	logic ram_we;
	logic [3*CW-1:0] ram_rdata;
	logic signed [AW-1:0] p0, p1, p2, p3, c0, c1, c2, opnd, mfrac;

	assign stat.op = op_q;
	assign stat.few = (count_q < NW'(4));
	assign stat.full = (count_q == NW'(crce_pkg::MAX_POINTS));

	assign prod = req.curve_param * count_q;
	assign idx_next = ({1'b0, idx_q} == count_q - NW'(1)) ? '0 : idx_q + IW'(1);
	assign ram_we = cmd.dispatch && op_q == crce_pkg::OP_APPEND && !stat.full;
	assign ram_addr = ram_we ? count_q[IW-1:0] : idx_q;

	crce_ram #(.WIDTH(3 * CW), .DEPTH(crce_pkg::MAX_POINTS)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({req_q.coord_z, req_q.coord_y, req_q.coord_x}),
		.rdata(ram_rdata)
	);

	assign p0 = AW'(pt_q[0][cmd.axis]);
	assign p1 = AW'(pt_q[1][cmd.axis]);
	assign p2 = AW'(pt_q[2][cmd.axis]);
	assign p3 = AW'(pt_q[3][cmd.axis]);
	assign c0 = -p0 + 3 * p1 - 3 * p2 + p3;
	assign c1 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
	assign c2 = p2 - p0;

	always_comb begin
		case (cmd.step)
			3'd0: opnd = c0;
			3'd1: opnd = 3 * c0;
			3'd2: opnd = hacc_q;
			3'd3: opnd = hacc_q;
			default: opnd = gacc_q;
		endcase
	end

	// An arithmetic shift of the exact product gives floor(h * t / 2^PW).
	assign mfrac = AW'(mul_q >>> PW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			op_q <= crce_pkg::OP_NONE;
		end else begin
			if (cmd.latch) op_q <= crce_pkg::op_t'(req.op);
			if (ram_we) count_q <= count_q + NW'(1);
			if (cmd.dispatch && op_q == crce_pkg::OP_CLEAR) count_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
			seg_q <= prod[PW+NW-1:PW];
			t_q <= prod[PW-1:0];
			status_q <= crce_pkg::STATUS_OK;
			for (int a = 0; a < 3; a++) begin
				pos_q[a] <= '0;
				tan_q[a] <= '0;
			end
		end
		if (cmd.dispatch) begin
			idx_q <= (seg_q == '0) ? IW'(count_q - NW'(1)) : IW'(seg_q - NW'(1));
			if (op_q == crce_pkg::OP_APPEND && stat.full) status_q <= crce_pkg::STATUS_FULL;
			if (op_q == crce_pkg::OP_EVAL && stat.few) status_q <= crce_pkg::STATUS_FEW;
		end
		if (cmd.rd_en) idx_q <= idx_next;
		if (cmd.cap_en) begin
			pt_q[cmd.cap_sel][0] <= ram_rdata[CW-1:0];
			pt_q[cmd.cap_sel][1] <= ram_rdata[2*CW-1:CW];
			pt_q[cmd.cap_sel][2] <= ram_rdata[3*CW-1:2*CW];
		end
		if (cmd.mul_en) mul_q <= opnd * $signed({1'b0, t_q});
		if (cmd.acc_en) begin
			case (cmd.step)
				3'd0: hacc_q <= mfrac + c1;
				3'd1: gacc_q <= mfrac + 2 * c1;
				3'd2: hacc_q <= mfrac + c2;
				3'd3: hacc_q <= mfrac;
				default: gacc_q <= mfrac + c2;
			endcase
		end
		if (cmd.fin_en) begin
			pos_q[cmd.axis] <= crce_pkg::sat_coord((AW+1)'(hacc_q >>> 1) + (AW+1)'(p1));
			tan_q[cmd.axis] <= crce_pkg::sat_coord((AW+1)'(gacc_q >>> 1));
		end
	end

	assign rsp.pos_x = pos_q[0];
	assign rsp.pos_y = pos_q[1];
	assign rsp.pos_z = pos_q[2];
	assign rsp.tan_x = tan_q[0];
	assign rsp.tan_y = tan_q[1];
	assign rsp.tan_z = tan_q[2];
	assign rsp.status = status_q;
endmodule

@@ rtl/catmull_rom_closed_curve_eval_core.sv @@
// Top level of the closed Catmull-Rom curve evaluator.
// A transaction is taken when start is high and busy is low; its single result is shown
// on rsp for one cycle with done high, and the receiver cannot stall it. Append, clear
// and unused-op transactions, and an evaluate with too few points, go from the dispatch
// state straight to done. Any other evaluate passes through a dispatch state, four
// sequential reads of the single-port point store plus the registered read, then for
// each of the three axes five multiply and accumulate passes of one shared fraction
// multiplier and a finishing step, before done. Busy drops the cycle after done, and
// only then can a new transaction be accepted.
// The store has no clearing pass after reset.
`timescale 1ns / 1ps
module catmull_rom_closed_curve_eval_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  crce_pkg::in_t  req,
	output logic           done,
	output crce_pkg::out_t rsp
);
	crce_pkg::cmd_t  cmd;
	crce_pkg::stat_t stat;

	crce_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.stat  (stat),
		.cmd   (cmd)
	);

	crce_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.rsp   (rsp)
	);
endmodule

@@ test/catmull_rom_closed_curve_eval_core_tb.sv @@
// Self-checking testbench of the closed Catmull-Rom curve evaluator core.
`timescale 1ns / 1ps
class curve_scoreboard;
	crce_pkg::out_t pending_results[$];
	longint point_coord[crce_pkg::MAX_POINTS][3];
	int unsigned point_total;
	int unsigned mismatches;

	function new();
		point_total = 0;
		mismatches = 0;
	endfunction

	static function longint frac_scale(longint h, longint t);
		longint r;
		longint q;
		r = h & ((longint'(1) << crce_pkg::PARAM_W) - 1);
		q = (h - r) >>> crce_pkg::PARAM_W;
		return q * t + ((r * t) >>> crce_pkg::PARAM_W);
	endfunction

	static function logic [crce_pkg::COORD_W-1:0] clamp_coord(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	// Works out the expected result of an accepted transaction.
	function void note_request(crce_pkg::in_t rq);
		crce_pkg::out_t r;
		longint n;
		longint prod;
		longint seg;
		longint t;
		longint p0, p1, p2, p3, c0, c1, c2, h, g;
		int i0;
		r = '0;
		n = point_total;
		if (rq.op == crce_pkg::OP_APPEND) begin
			if (point_total >= crce_pkg::MAX_POINTS) begin
				r.status = crce_pkg::STATUS_FULL;
			end else begin
				point_coord[point_total][0] = longint'(rq.coord_x);
				point_coord[point_total][1] = longint'(rq.coord_y);
				point_coord[point_total][2] = longint'(rq.coord_z);
				point_total++;
			end
		end else if (rq.op == crce_pkg::OP_EVAL) begin
			if (n < 4) begin
				r.status = crce_pkg::STATUS_FEW;
			end else begin
				prod = longint'(rq.curve_param) * n;
				seg = prod >> crce_pkg::PARAM_W;
				t = prod & ((longint'(1) << crce_pkg::PARAM_W) - 1);
				i0 = int'((seg + n - 1) % n);
				for (int ax = 0; ax < 3; ax++) begin
					p0 = point_coord[i0][ax];
					p1 = point_coord[(i0 + 1) % n][ax];
					p2 = point_coord[(i0 + 2) % n][ax];
					p3 = point_coord[(i0 + 3) % n][ax];
					c0 = -p0 + 3 * p1 - 3 * p2 + p3;
					c1 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
					c2 = p2 - p0;
					h = frac_scale(c0, t) + c1;
					g = frac_scale(3 * c0, t) + 2 * c1;
					h = frac_scale(frac_scale(h, t) + c2, t);
					g = frac_scale(g, t) + c2;
					// Arithmetic shift is a floor division by two.
					case (ax)
						0: begin
							r.pos_x = clamp_coord((h >>> 1) + p1);
							r.tan_x = clamp_coord(g >>> 1);
						end
						1: begin
							r.pos_y = clamp_coord((h >>> 1) + p1);
							r.tan_y = clamp_coord(g >>> 1);
						end
						default: begin
							r.pos_z = clamp_coord((h >>> 1) + p1);
							r.tan_z = clamp_coord(g >>> 1);
						end
					endcase
				end
			end
		end else if (rq.op == crce_pkg::OP_CLEAR) begin
			point_total = 0;
		end
		pending_results.insert(pending_results.size(), r);
	endfunction

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task check_result(crce_pkg::out_t got);
		crce_pkg::out_t w;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected transaction", 0, 0);
			return;
		end
		w = pending_results.pop_front();
		if (got.pos_x !== w.pos_x) report_mismatch("pos_x", got.pos_x, w.pos_x);
		if (got.pos_y !== w.pos_y) report_mismatch("pos_y", got.pos_y, w.pos_y);
		if (got.pos_z !== w.pos_z) report_mismatch("pos_z", got.pos_z, w.pos_z);
		if (got.tan_x !== w.tan_x) report_mismatch("tan_x", got.tan_x, w.tan_x);
		if (got.tan_y !== w.tan_y) report_mismatch("tan_y", got.tan_y, w.tan_y);
		if (got.tan_z !== w.tan_z) report_mismatch("tan_z", got.tan_z, w.tan_z);
		if (got.status !== w.status) report_mismatch("status", got.status, w.status);
	endtask
endclass

module catmull_rom_closed_curve_eval_core_tb;
	import crce_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	in_t req = '0;
	out_t rsp;
	int gap_pct = 32;
	int idle_cycles = 0;
	curve_scoreboard board;

	catmull_rom_closed_curve_eval_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #10 clk = ~clk;

	initial board = new();

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_result(rsp);
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic logic [31:0] edgy_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 8) << 16;
			default: return $urandom;
		endcase
	endfunction

	// Presents one transaction and holds it until the block takes it.
	task automatic send(op_t op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] gt);
		in_t rq;
		rq.op = op;
		rq.coord_x = x;
		rq.coord_y = y;
		rq.coord_z = z;
		rq.curve_param = gt[15:0];
		@(posedge clk);
		while ($urandom_range(0, 99) < gap_pct) @(posedge clk);
		start <= 1'b1;
		req <= rq;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_request(rq);
		start <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		int k;
		int pts;
		k = 0;
		while (k < count) begin
			// Mostly a fresh loop of points followed by evaluations.
			if ($urandom_range(0, 9) < 7) begin
				send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
				pts = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66)
					: $urandom_range(3, 10);
				for (int p = 0; p < pts; p++)
					send(OP_APPEND, edgy_coord(), edgy_coord(), edgy_coord(), $urandom);
				for (int e = 0; e < 8; e++)
					send(OP_EVAL, $urandom, $urandom, $urandom, $urandom);
				k += pts + 9;
			end else begin
				send(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
				k++;
			end
		end
	endtask

	initial begin
		gap_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: too few points, unused op, then extremes and wrap-around.
		send(OP_EVAL, 0, 0, 0, 32'h0000);
		send(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffff);
		send(OP_APPEND, 32'h7fffffff, 32'h80000000, 32'h00010000, 0);
		send(OP_APPEND, 32'h80000000, 32'h7fffffff, 32'hffff0000, 0);
		send(OP_APPEND, 32'h7fffffff, 32'h80000000, 32'h00000000, 0);
		send(OP_EVAL, 0, 0, 0, 32'h8000);
		send(OP_APPEND, 32'h80000000, 32'h7fffffff, 32'hffffffff, 0);
		send(OP_EVAL, 0, 0, 0, 32'h0000);
		send(OP_EVAL, 0, 0, 0, 32'hffff);
		send(OP_EVAL, 0, 0, 0, 32'h7fff);
		send(OP_EVAL, 0, 0, 0, 32'hc000);
		send(OP_CLEAR, 0, 0, 0, 0);
		send(OP_EVAL, 0, 0, 0, 32'h1234);
		for (int p = 0; p < MAX_POINTS; p++)
			send(OP_APPEND, $urandom, $urandom, $urandom, 0);
		send(OP_APPEND, 32'h1, 32'h2, 32'h3, 0);
		send(OP_EVAL, 0, 0, 0, 32'hffff);
		send(OP_EVAL, 0, 0, 0, 32'h0001);
		drain();
		gap_pct = 32;
		random_phase(600);
		// Hold off until every expected transaction has come back.
		drain();
		gap_pct = 60;
		random_phase(600);
		gap_pct = 0;
		random_phase(600);
		drain();
		repeat (50) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
